### rtl/muscl_van_leer_reconstruct_macros.svh
// assertion helpers shared by the reconstruction rtl
`ifndef MUSCL_VAN_LEER_RECONSTRUCT_MACROS_SVH
`define MUSCL_VAN_LEER_RECONSTRUCT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MVL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define MVL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/mvl_pkg.sv
package mvl_pkg;

   localparam int VAL_W     = 48;
   localparam int WIDE_W    = 56;
   localparam int A_W       = 49;
   localparam int REM_W     = 51;
   localparam int MUL_W     = 50;
   localparam int SUM_W     = 52;
   localparam int DIV_W     = 51;
   localparam int RCP_W     = 64;
   localparam int DIV_LAT   = 9;
   localparam int CORR_W    = 49;
   localparam int HALF_W    = 24;
   localparam int PROD_W    = 97;
   localparam int MUL_LAT   = 4;

   typedef enum logic [1:0] {
      PHI_DIV,
      PHI_ZERO,
      PHI_INF
   } phi_code_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] left_value;
      logic signed [VAL_W-1:0] right_value;
      logic signed [VAL_W-1:0] grad_left_x;
      logic signed [VAL_W-1:0] grad_left_y;
      logic signed [VAL_W-1:0] grad_left_z;
      logic signed [VAL_W-1:0] grad_right_x;
      logic signed [VAL_W-1:0] grad_right_y;
      logic signed [VAL_W-1:0] grad_right_z;
      logic signed [VAL_W-1:0] edge_dx;
      logic signed [VAL_W-1:0] edge_dy;
      logic signed [VAL_W-1:0] edge_dz;
   } req_payload_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] left_recon;
      logic signed [VAL_W-1:0] right_recon;
      logic                    saturated;
   } rsp_payload_type;

   // values that ride along the pipeline next to the arithmetic units
   typedef struct packed {
      logic signed [VAL_W-1:0] lv;
      logic signed [VAL_W-1:0] rv;
      logic signed [VAL_W-1:0] d1;
      logic signed [VAL_W-1:0] d2;
      logic signed [VAL_W-1:0] d3;
      logic                    sat;
   } carry_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] val;
      logic                    sat;
   } sat_val_type;

   function automatic sat_val_type clamp48(input logic signed [WIDE_W-1:0] v);
      sat_val_type r;
      if (&v[WIDE_W-1:VAL_W-1] || ~|v[WIDE_W-1:VAL_W-1]) begin
         r.val = v[VAL_W-1:0];
         r.sat = 1'b0;
      end else begin
         r.val = v[WIDE_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
         r.sat = 1'b1;
      end
      return r;
   endfunction

endpackage

### rtl/mvl_stream_if.sv
interface mvl_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/mvl_mul.sv
module mvl_mul #(
   parameter int FRAC_BITS = 32,
   parameter int OUT_W = 48
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [mvl_pkg::VAL_W-1:0] a,
   input  logic signed [mvl_pkg::VAL_W-1:0] b,
   output logic signed [OUT_W-1:0]        p,
   output logic                           sat
);
   import mvl_pkg::*;

   logic [VAL_W-1:0] ua1_ff, ub1_ff, ua1_in, ub1_in;
   logic neg1_ff, neg2_ff, neg3_ff;
   logic [2*HALF_W-1:0] pp_ff [4];
   logic [2*HALF_W-1:0] pp_in [4];
   logic [PROD_W-1:0] sum_ff, sum_in;
   logic signed [OUT_W-1:0] p_ff, p_in;
   logic sat_ff, sat_in;

   always_comb begin
      ua1_in = a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
      ub1_in = b[VAL_W-1] ? VAL_W'(-b) : VAL_W'(b);
   end

   // four half-width partial products
   always_comb begin
      pp_in[0] = ua1_ff[HALF_W-1:0] * ub1_ff[HALF_W-1:0];
      pp_in[1] = ua1_ff[HALF_W-1:0] * ub1_ff[2*HALF_W-1:HALF_W];
      pp_in[2] = ua1_ff[2*HALF_W-1:HALF_W] * ub1_ff[HALF_W-1:0];
      pp_in[3] = ua1_ff[2*HALF_W-1:HALF_W] * ub1_ff[2*HALF_W-1:HALF_W];
   end

   // full product plus half an lsb for rounding away from zero
   always_comb begin
      sum_in = PROD_W'({pp_ff[3], {(2*HALF_W){1'b0}}})
             + PROD_W'({pp_ff[2], {HALF_W{1'b0}}})
             + PROD_W'({pp_ff[1], {HALF_W{1'b0}}})
             + PROD_W'(pp_ff[0])
             + (PROD_W'(1) << (FRAC_BITS - 1));
   end

   always_comb begin
      logic [PROD_W-1:0] rnd, lim;
      logic [OUT_W-1:0] mag;
      rnd = sum_ff >> FRAC_BITS;
      lim = PROD_W'(1) << (OUT_W - 1);
      if (!neg3_ff) lim = lim - PROD_W'(1);
      if (rnd > lim) begin
         mag = lim[OUT_W-1:0];
         sat_in = 1'b1;
      end else begin
         mag = rnd[OUT_W-1:0];
         sat_in = 1'b0;
      end
      p_in = neg3_ff ? -mag : mag;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ua1_ff <= ua1_in;
         ub1_ff <= ub1_in;
         neg1_ff <= a[VAL_W-1] ^ b[VAL_W-1];
         for (int i = 0; i < 4; i++) pp_ff[i] <= pp_in[i];
         neg2_ff <= neg1_ff;
         sum_ff <= sum_in;
         neg3_ff <= neg2_ff;
         p_ff <= p_in;
         sat_ff <= sat_in;
      end
   end

   assign p = p_ff;
   assign sat = sat_ff;
endmodule

### rtl/mvl_phi.sv
module mvl_phi #(
   parameter int FRAC_BITS = 32
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [mvl_pkg::A_W-1:0] num,
   input  logic signed [mvl_pkg::A_W-1:0] den,
   output logic [FRAC_BITS+1:0]           phi
);
   import mvl_pkg::*;

   localparam int NS = FRAC_BITS + 2;

   phi_code_type code1_ff, code1_in;
   logic [A_W-1:0] un1_ff, ud1_ff;
   phi_code_type code_st_ff [NS+1];
   logic [REM_W-1:0] s_st_ff [NS+1];
   logic [REM_W-1:0] r_st_ff [NS+1];
   logic [NS-1:0] q_st_ff [NS+1];
   logic [REM_W-1:0] r_st_in [NS];
   logic [NS-1:0] q_st_in [NS];
   logic [FRAC_BITS+1:0] phi_ff, phi_in;

   always_comb begin
      if (num == '0) code1_in = PHI_ZERO;
      else if (den == '0) code1_in = PHI_INF;
      else if (num[A_W-1] != den[A_W-1]) code1_in = PHI_ZERO;
      else code1_in = PHI_DIV;
   end

   // restoring division of 2|n| by |n|+|d|, one quotient bit per stage
   always_comb begin
      logic [REM_W-1:0] r_cur;
      logic [NS-1:0] q_cur;
      for (int j = 0; j < NS; j++) begin
         r_cur = (j == 0) ? r_st_ff[j] : (r_st_ff[j] << 1);
         q_cur = q_st_ff[j] << 1;
         if (r_cur >= s_st_ff[j]) begin
            r_st_in[j] = r_cur - s_st_ff[j];
            q_st_in[j] = q_cur | NS'(1);
         end else begin
            r_st_in[j] = r_cur;
            q_st_in[j] = q_cur;
         end
      end
   end

   // the extra quotient bit rounds half up
   always_comb begin
      logic [NS:0] q_round;
      q_round = {1'b0, q_st_ff[NS]} + (NS+1)'(1);
      phi_in = '0;
      case (code_st_ff[NS])
         PHI_DIV: phi_in = q_round[NS:1];
         PHI_INF: phi_in[FRAC_BITS+1] = 1'b1;
         default: phi_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         code1_ff <= code1_in;
         un1_ff <= num[A_W-1] ? A_W'(-num) : A_W'(num);
         ud1_ff <= den[A_W-1] ? A_W'(-den) : A_W'(den);
         code_st_ff[0] <= code1_ff;
         s_st_ff[0] <= REM_W'(un1_ff) + REM_W'(ud1_ff);
         r_st_ff[0] <= REM_W'(un1_ff) << 1;
         q_st_ff[0] <= '0;
         for (int j = 0; j < NS; j++) begin
            code_st_ff[j+1] <= code_st_ff[j];
            s_st_ff[j+1] <= s_st_ff[j];
            r_st_ff[j+1] <= r_st_in[j];
            q_st_ff[j+1] <= q_st_in[j];
         end
         phi_ff <= phi_in;
      end
   end

   assign phi = phi_ff;
endmodule

### rtl/mvl_div6.sv
module mvl_div6 (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [mvl_pkg::SUM_W-1:0]  num,
   output logic signed [mvl_pkg::CORR_W-1:0] quo
);
   import mvl_pkg::*;

   localparam int P_W = DIV_W + RCP_W;

   logic [DIV_W-1:0] y_ff [7];
   logic neg_ff [8];
   logic [DIV_W-1:0] y0_in;
   logic [P_W-1:0] p_ff [5];
   logic [P_W-1:0] p_in [5];
   logic [DIV_W-1:0] qe_ff, q8_ff;
   logic cor_ff, cor_in;
   logic signed [CORR_W-1:0] quo_ff, quo_in;

   // half of magnitude plus three; its floor over three is x / 6 rounded half away from zero
   always_comb begin
      logic [SUM_W-1:0] m, x;
      m = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
      x = m + SUM_W'(3);
      y0_in = x[SUM_W-1:1];
   end

   // multiply by the repeated 01 pattern in doublings, an estimate of y / 3
   always_comb begin
      p_in[0] = P_W'(y_ff[0]) + (P_W'(y_ff[0]) << 2);
      for (int k = 1; k < 5; k++) p_in[k] = p_ff[k-1] + (p_ff[k-1] << (2 << k));
   end

   // the estimate is low by at most one
   always_comb begin
      logic [DIV_W+1:0] r;
      r = (DIV_W+2)'(y_ff[6]) - (DIV_W+2)'(qe_ff) - ((DIV_W+2)'(qe_ff) << 1);
      cor_in = (r >= (DIV_W+2)'(3));
   end

   always_comb begin
      logic [DIV_W-1:0] qs;
      logic [CORR_W-1:0] qn;
      qs = q8_ff + DIV_W'(cor_ff);
      qn = qs[CORR_W-1:0];
      quo_in = neg_ff[7] ? -qn : qn;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff[0] <= y0_in;
         neg_ff[0] <= num[SUM_W-1];
         for (int k = 1; k < 7; k++) y_ff[k] <= y_ff[k-1];
         for (int k = 1; k < 8; k++) neg_ff[k] <= neg_ff[k-1];
         for (int k = 0; k < 5; k++) p_ff[k] <= p_in[k];
         qe_ff <= p_ff[4][P_W-1:RCP_W];
         q8_ff <= qe_ff;
         cor_ff <= cor_in;
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;
endmodule

### rtl/muscl_van_leer_reconstruct.sv
// MUSCL edge reconstruction with the van Leer limiter, signed fixed point with FRAC_BITS
// fraction bits on 48-bit fields. One edge transaction is accepted every cycle while the
// skid entry is empty, and results leave in order, one per transaction. The depth is set
// mostly by the limiter divider, which resolves one quotient bit per stage; the 48-bit
// products take four stages each and the rounded division by six takes nine. An output
// register plus a skid entry decouple the two channels, so the input keeps flowing while
// one result waits, and a stall on the result side freezes the whole pipeline without
// dropping or repeating anything.
`include "muscl_van_leer_reconstruct_macros.svh"

module muscl_van_leer_reconstruct #(
   parameter int FRAC_BITS = 32
) (
   input logic          clock,
   input logic          reset,
   mvl_stream_if.sink   req_ch,
   mvl_stream_if.source rsp_ch
);
   import mvl_pkg::*;

   localparam int PHI_LAT = FRAC_BITS + 5;
   localparam int LAST = 6 + PHI_LAT + MUL_LAT + 1 + DIV_LAT + 1;
   localparam longint EPS_Q =
      ((longint'(1) << FRAC_BITS) + longint'(500000000)) / longint'(1000000000);
   localparam logic signed [A_W-1:0] EPS_A = A_W'(EPS_Q);

   logic en;
   logic [LAST:0] v_ff;
   req_payload_type in_ff;

   logic signed [VAL_W-1:0] gl [3];
   logic signed [VAL_W-1:0] gr [3];
   logic signed [VAL_W-1:0] ev [3];
   logic signed [VAL_W-1:0] ml [3];
   logic signed [VAL_W-1:0] mr [3];
   logic [2:0] sl, sr;

   carry_type c1_in, c5_in;
   carry_type c1_ff [MUL_LAT];
   carry_type c5_ff, c6_ff;
   carry_type c2_ff [PHI_LAT];
   carry_type c3_ff [MUL_LAT];
   carry_type cs_ff, cs_in;
   carry_type c4_ff [DIV_LAT];
   logic signed [A_W-1:0] a1_ff, a2_ff, a3_ff;
   logic [FRAC_BITS+1:0] phi_l, phi_li, phi_r, phi_ri;
   logic signed [MUL_W-1:0] ma_l, mb_l, ma_r, mb_r;
   logic [3:0] sm;
   logic signed [SUM_W-1:0] vl_ff, vr_ff;
   logic signed [CORR_W-1:0] corr_l, corr_r;
   rsp_payload_type res_ff, res_in;

   rsp_payload_type out_ff, out_in, skid_ff, skid_in;
   logic out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   assign en = !skid_valid_ff;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAST-1:0], req_ch.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) in_ff <= req_ch.payload;
   end

   // dot products of both gradients with the edge vector
   assign gl[0] = in_ff.grad_left_x;
   assign gl[1] = in_ff.grad_left_y;
   assign gl[2] = in_ff.grad_left_z;
   assign gr[0] = in_ff.grad_right_x;
   assign gr[1] = in_ff.grad_right_y;
   assign gr[2] = in_ff.grad_right_z;
   assign ev[0] = in_ff.edge_dx;
   assign ev[1] = in_ff.edge_dy;
   assign ev[2] = in_ff.edge_dz;

   for (genvar i = 0; i < 3; i++) begin : g_dot
      mvl_mul #(.FRAC_BITS(FRAC_BITS), .OUT_W(VAL_W)) u_mul_l (
         .clock, .en, .a(gl[i]), .b(ev[i]), .p(ml[i]), .sat(sl[i]));
      mvl_mul #(.FRAC_BITS(FRAC_BITS), .OUT_W(VAL_W)) u_mul_r (
         .clock, .en, .a(gr[i]), .b(ev[i]), .p(mr[i]), .sat(sr[i]));
   end

   always_comb begin
      sat_val_type d2;
      d2 = clamp48(WIDE_W'($signed(in_ff.right_value)) - WIDE_W'($signed(in_ff.left_value)));
      c1_in.lv = in_ff.left_value;
      c1_in.rv = in_ff.right_value;
      c1_in.d1 = '0;
      c1_in.d2 = d2.val;
      c1_in.d3 = '0;
      c1_in.sat = d2.sat;
   end

   // extrapolated differences 2 (g . e) - d2
   always_comb begin
      logic signed [WIDE_W-1:0] dl, dr, d2w;
      sat_val_type e1, e3;
      dl = WIDE_W'(ml[0]) + WIDE_W'(ml[1]) + WIDE_W'(ml[2]);
      dr = WIDE_W'(mr[0]) + WIDE_W'(mr[1]) + WIDE_W'(mr[2]);
      d2w = WIDE_W'($signed(c1_ff[MUL_LAT-1].d2));
      e1 = clamp48((dl <<< 1) - d2w);
      e3 = clamp48((dr <<< 1) - d2w);
      c5_in = c1_ff[MUL_LAT-1];
      c5_in.d1 = e1.val;
      c5_in.d3 = e3.val;
      c5_in.sat = c1_ff[MUL_LAT-1].sat | (|sl) | (|sr) | e1.sat | e3.sat;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff[0] <= c1_in;
         for (int k = 1; k < MUL_LAT; k++) c1_ff[k] <= c1_ff[k-1];
         c5_ff <= c5_in;
         c6_ff <= c5_ff;
         a1_ff <= A_W'($signed(c5_ff.d1)) + EPS_A;
         a2_ff <= A_W'($signed(c5_ff.d2)) + EPS_A;
         a3_ff <= A_W'($signed(c5_ff.d3)) + EPS_A;
      end
   end

   // limiter for forward and inverse ratios on each side
   mvl_phi #(.FRAC_BITS(FRAC_BITS)) u_phi_l (
      .clock, .en, .num(a2_ff), .den(a1_ff), .phi(phi_l));
   mvl_phi #(.FRAC_BITS(FRAC_BITS)) u_phi_li (
      .clock, .en, .num(a1_ff), .den(a2_ff), .phi(phi_li));
   mvl_phi #(.FRAC_BITS(FRAC_BITS)) u_phi_r (
      .clock, .en, .num(a2_ff), .den(a3_ff), .phi(phi_r));
   mvl_phi #(.FRAC_BITS(FRAC_BITS)) u_phi_ri (
      .clock, .en, .num(a3_ff), .den(a2_ff), .phi(phi_ri));

   always_ff @(posedge clock) begin
      if (en) begin
         c2_ff[0] <= c6_ff;
         for (int k = 1; k < PHI_LAT; k++) c2_ff[k] <= c2_ff[k-1];
      end
   end

   mvl_mul #(.FRAC_BITS(FRAC_BITS), .OUT_W(MUL_W)) u_lim_la (
      .clock, .en, .a(c2_ff[PHI_LAT-1].d1), .b(VAL_W'(phi_l)), .p(ma_l), .sat(sm[0]));
   mvl_mul #(.FRAC_BITS(FRAC_BITS), .OUT_W(MUL_W)) u_lim_lb (
      .clock, .en, .a(c2_ff[PHI_LAT-1].d2), .b(VAL_W'(phi_li)), .p(mb_l), .sat(sm[1]));
   mvl_mul #(.FRAC_BITS(FRAC_BITS), .OUT_W(MUL_W)) u_lim_ra (
      .clock, .en, .a(c2_ff[PHI_LAT-1].d3), .b(VAL_W'(phi_r)), .p(ma_r), .sat(sm[2]));
   mvl_mul #(.FRAC_BITS(FRAC_BITS), .OUT_W(MUL_W)) u_lim_rb (
      .clock, .en, .a(c2_ff[PHI_LAT-1].d2), .b(VAL_W'(phi_ri)), .p(mb_r), .sat(sm[3]));

   always_comb begin
      cs_in = c3_ff[MUL_LAT-1];
      cs_in.sat = c3_ff[MUL_LAT-1].sat | (|sm);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c3_ff[0] <= c2_ff[PHI_LAT-1];
         for (int k = 1; k < MUL_LAT; k++) c3_ff[k] <= c3_ff[k-1];
         vl_ff <= SUM_W'(ma_l) + (SUM_W'(mb_l) <<< 1);
         vr_ff <= SUM_W'(ma_r) + (SUM_W'(mb_r) <<< 1);
         cs_ff <= cs_in;
      end
   end

   mvl_div6 u_div_l (.clock, .en, .num(vl_ff), .quo(corr_l));
   mvl_div6 u_div_r (.clock, .en, .num(vr_ff), .quo(corr_r));

   always_comb begin
      sat_val_type lr, rr;
      lr = clamp48(WIDE_W'($signed(c4_ff[DIV_LAT-1].lv)) + WIDE_W'(corr_l));
      rr = clamp48(WIDE_W'($signed(c4_ff[DIV_LAT-1].rv)) - WIDE_W'(corr_r));
      res_in.left_recon = lr.val;
      res_in.right_recon = rr.val;
      res_in.saturated = c4_ff[DIV_LAT-1].sat | lr.sat | rr.sat;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c4_ff[0] <= cs_ff;
         for (int k = 1; k < DIV_LAT; k++) c4_ff[k] <= c4_ff[k-1];
         res_ff <= res_in;
      end
   end

   // output register with one skid entry behind it
   always_comb begin
      out_in = out_ff;
      skid_in = skid_ff;
      out_valid_in = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_ch.ready) begin
            out_in = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (v_ff[LAST]) begin
         if (!out_valid_ff || rsp_ch.ready) begin
            out_in = res_ff;
            out_valid_in = 1'b1;
         end else begin
            skid_in = res_ff;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.payload = out_ff;

   `MVL_ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid full with output empty")
   `MVL_ASSERT_NEXT(a_skid_catch, clock, reset, v_ff[LAST] && en && out_valid_ff && !rsp_ch.ready, skid_valid_ff, "result lost while output stalled")
   `MVL_ASSERT_NEXT(a_accept_enters, clock, reset, req_ch.valid && req_ch.ready, v_ff[0], "accepted transaction missing in first stage")
endmodule
